// ----- rtl/ilt_pkg.sv -----
// Shared types and constants for the INI line tokenizer.
// No dependencies.
`timescale 1ns / 1ps
package ilt_pkg;
	typedef enum logic [2:0] {
		PH_LINE_START = 3'd0,
		PH_SECTION    = 3'd1,
		PH_KEY        = 3'd2,
		PH_VAL_START  = 3'd3,
		PH_UNQUOTED   = 3'd4,
		PH_QUOTED     = 3'd5,
		PH_TRAIL      = 3'd6,
		PH_IGNORE     = 3'd7
	} phase_t;

	localparam logic [2:0] K_SECT = 3'd0;
	localparam logic [2:0] K_KEY  = 3'd1;
	localparam logic [2:0] K_VAL  = 3'd2;
	localparam logic [2:0] K_LINE = 3'd3;
	localparam logic [2:0] K_ERR  = 3'd4;
	localparam logic [2:0] K_FILE = 3'd5;

	localparam logic [7:0] CH_QUOTE  = 8'd34;
	localparam logic [7:0] CH_HASH   = 8'd35;
	localparam logic [7:0] CH_SEMI   = 8'd59;
	localparam logic [7:0] CH_LBRACK = 8'd91;
	localparam logic [7:0] CH_RBRACK = 8'd93;
	localparam logic [7:0] CH_EQ     = 8'd61;
	localparam logic [7:0] CH_COLON  = 8'd58;
	localparam logic [7:0] CH_NL     = 8'd10;
	localparam logic [7:0] CH_NUL    = 8'd0;

	localparam logic [23:0] LINE_SAT = 24'hFFFFFF;

	// Command from the classifier to the emitter.
	typedef struct packed {
		logic        flush;    // emit held spaces first
		logic [5:0]  nflush;   // number of held spaces
		logic        emit;     // emit one token after flush
		logic [2:0]  kind;
		logic [7:0]  ch;
		logic [1:0]  ltype;
		logic [23:0] num;
	} cmd_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
	endfunction

	function automatic logic is_remark(input logic [7:0] c);
		return (c == CH_HASH) || (c == CH_SEMI);
	endfunction
endpackage

// ----- rtl/ilt_front.sv -----
// Front part: accepts bytes, runs the line parser, writes the space store
// and issues emitter commands. Depends on ilt_pkg.
`timescale 1ns / 1ps
module ilt_front #(
	parameter int MAX_SECTION_CHARS = 200,
	parameter int MAX_LINE_CHARS    = 4095,
	parameter int PENDING_DEPTH     = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_eof,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output ilt_pkg::cmd_t       cmd,
	output logic                wr_en,
	output logic [4:0]          wr_addr,
	output logic [7:0]          wr_data
);
	import ilt_pkg::*;

	phase_t      phase_q, phase_d;
	logic [5:0]  pcnt_q, pcnt_d;
	logic [7:0]  slen_q, slen_d;
	logic [11:0] llen_q, llen_d;
	logic [23:0] lcnt_q, lcnt_d;
	logic [23:0] ferr_q, ferr_d;
	logic        bad_q, bad_d;
	logic [1:0]  ltype_q, ltype_d;
	logic        vne_q, vne_d;
	logic        stop_q, stop_d;
	logic        go;
	cmd_t        c;
	logic        cv;

	assign in_ready = cmd_ready;
	assign go = in_valid && in_ready;
	assign cmd = c;
	assign cmd_valid = go && cv;

	always_comb begin
		logic [23:0] ln;
		logic        lbad;
		logic [1:0]  ty;
		phase_d = phase_q; pcnt_d = pcnt_q; slen_d = slen_q; llen_d = llen_q;
		lcnt_d = lcnt_q; ferr_d = ferr_q; bad_d = bad_q; ltype_d = ltype_q;
		vne_d = vne_q; stop_d = stop_q;
		c = '0; cv = 1'b0;
		wr_en = 1'b0; wr_addr = pcnt_q[4:0]; wr_data = in_byte;
		ln = lcnt_q; lbad = 1'b0; ty = ltype_q;
		if (in_eof) begin
			cv = 1'b1; c.emit = 1'b1; c.kind = K_FILE; c.num = ferr_q;
			phase_d = PH_LINE_START; pcnt_d = '0; slen_d = '0; llen_d = '0;
			bad_d = 1'b0; ltype_d = '0; vne_d = 1'b0;
			lcnt_d = '0; ferr_d = '0; stop_d = 1'b0;
		end else if (stop_q) begin
			cv = 1'b0;
		end else if (in_byte == CH_NL) begin
			lbad = bad_q || phase_q == PH_SECTION || phase_q == PH_KEY ||
				phase_q == PH_QUOTED;
			if (lcnt_q != LINE_SAT) ln = lcnt_q + 24'd1;
			lcnt_d = ln;
			cv = 1'b1; c.emit = 1'b1; c.num = ln;
			if (lbad) begin
				ferr_d = ln; stop_d = 1'b1; c.kind = K_ERR;
			end else begin
				if (ty == 2'd2 && !vne_q) ty = 2'd3;
				c.kind = K_LINE; c.ltype = ty;
			end
			phase_d = PH_LINE_START; pcnt_d = '0; slen_d = '0; llen_d = '0;
			bad_d = 1'b0; ltype_d = '0; vne_d = 1'b0;
		end else begin
			c.ch = in_byte; c.nflush = pcnt_q;
			if (32'(llen_q) >= MAX_LINE_CHARS - 1) begin
				bad_d = 1'b1; phase_d = PH_IGNORE; pcnt_d = '0;
			end else llen_d = llen_q + 12'd1;
			// phase_q is the old phase; a length fault above forces ignore
			if (phase_q != PH_IGNORE && phase_d != PH_IGNORE) begin
				if (in_byte == CH_NUL) begin
					if (phase_q == PH_SECTION || phase_q == PH_KEY ||
						phase_q == PH_QUOTED) bad_d = 1'b1;
					pcnt_d = '0; phase_d = PH_IGNORE;
				end else begin
					unique case (phase_q)
						PH_LINE_START: begin
							if (is_ws(in_byte)) begin
							end else if (in_byte == CH_LBRACK) begin
								ltype_d = 2'd1; slen_d = '0; phase_d = PH_SECTION;
							end else if (is_letter(in_byte)) begin
								ltype_d = 2'd2; phase_d = PH_KEY;
								cv = 1'b1; c.emit = 1'b1; c.kind = K_KEY;
							end else if (is_remark(in_byte)) phase_d = PH_IGNORE;
							else begin bad_d = 1'b1; phase_d = PH_IGNORE; pcnt_d = '0; end
						end
						PH_SECTION: begin
							if (in_byte == CH_RBRACK) phase_d = PH_TRAIL;
							else if (32'(slen_q) >= MAX_SECTION_CHARS) begin
								bad_d = 1'b1; phase_d = PH_IGNORE; pcnt_d = '0;
							end else begin
								slen_d = slen_q + 8'd1;
								cv = 1'b1; c.emit = 1'b1; c.kind = K_SECT;
							end
						end
						PH_KEY, PH_UNQUOTED: begin
							if (phase_q == PH_KEY && (in_byte == CH_EQ ||
								in_byte == CH_COLON)) begin
								pcnt_d = '0; phase_d = PH_VAL_START;
							end else if (phase_q == PH_UNQUOTED && is_remark(in_byte)) begin
								pcnt_d = '0; phase_d = PH_IGNORE;
							end else if (is_ws(in_byte)) begin
								if (32'(pcnt_q) >= PENDING_DEPTH) begin
									bad_d = 1'b1; phase_d = PH_IGNORE; pcnt_d = '0;
								end else begin
									// write only on an accepted transaction
									wr_en = go; pcnt_d = pcnt_q + 6'd1;
								end
							end else begin
								cv = 1'b1; c.flush = (pcnt_q != 6'd0); c.emit = 1'b1;
								c.kind = (phase_q == PH_KEY) ? K_KEY : K_VAL;
								pcnt_d = '0;
								if (phase_q == PH_UNQUOTED) vne_d = 1'b1;
							end
						end
						PH_VAL_START: begin
							if (is_ws(in_byte)) begin
							end else if (in_byte == CH_QUOTE) phase_d = PH_QUOTED;
							else if (is_remark(in_byte)) phase_d = PH_IGNORE;
							else begin
								phase_d = PH_UNQUOTED; vne_d = 1'b1;
								cv = 1'b1; c.emit = 1'b1; c.kind = K_VAL;
							end
						end
						PH_QUOTED: begin
							if (in_byte == CH_QUOTE) phase_d = PH_TRAIL;
							else begin
								vne_d = 1'b1; cv = 1'b1; c.emit = 1'b1; c.kind = K_VAL;
							end
						end
						PH_TRAIL: begin
							if (is_ws(in_byte)) begin
							end else if (is_remark(in_byte)) phase_d = PH_IGNORE;
							else begin bad_d = 1'b1; phase_d = PH_IGNORE; pcnt_d = '0; end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LINE_START; pcnt_q <= '0; slen_q <= '0; llen_q <= '0;
			lcnt_q <= '0; ferr_q <= '0; bad_q <= 1'b0; ltype_q <= '0;
			vne_q <= 1'b0; stop_q <= 1'b0;
		end else if (go) begin
			phase_q <= phase_d; pcnt_q <= pcnt_d; slen_q <= slen_d;
			llen_q <= llen_d; lcnt_q <= lcnt_d; ferr_q <= ferr_d; bad_q <= bad_d;
			ltype_q <= ltype_d; vne_q <= vne_d; stop_q <= stop_d;
		end
	end
endmodule

// ----- rtl/ilt_back.sv -----
// Back part: command queue, pending-space memory and token emitter.
// Depends on ilt_pkg.
`timescale 1ns / 1ps
module ilt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  ilt_pkg::cmd_t cmd,
	input  logic          wr_en,
	input  logic [4:0]    wr_addr,
	input  logic [7:0]    wr_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [2:0]    kind,
	output logic [7:0]    ch,
	output logic [1:0]    ltype,
	output logic [23:0]   num,
	output logic          last
);
	import ilt_pkg::*;

	// Two-entry queue. A flush copies the held spaces out of the memory,
	// which the front may overwrite for the next run; snapshot is kept in
	// a second bank selected per command.
	logic [7:0] mem0_q [0:31];
	logic [7:0] mem1_q [0:31];
	logic       wbank_q;
	cmd_t       qd_q [0:1];
	logic       qb_q [0:1];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	logic [5:0] idx_q;
	logic       go_out;
	logic       pop;
	cmd_t       h;
	logic       hb;
	logic       in_flush;

	assign h = qd_q[rd_q];
	assign hb = qb_q[rd_q];
	assign cmd_ready = (cnt_q != 2'd2);
	assign in_flush = h.flush && (idx_q < h.nflush);

	// Write always into the current bank; a flush command switches banks
	// so the next run cannot clobber spaces still queued.
	always_ff @(posedge clk) begin
		if (wr_en && !wbank_q) mem0_q[wr_addr] <= wr_data;
		if (wr_en && wbank_q) mem1_q[wr_addr] <= wr_data;
	end

	logic [7:0] rdat;
	assign rdat = hb ? mem1_q[idx_q[4:0]] : mem0_q[idx_q[4:0]];

	assign out_valid = (cnt_q != 2'd0) && (in_flush || h.emit);
	assign kind  = in_flush ? h.kind : h.kind;
	assign ch    = in_flush ? rdat : h.ch;
	assign ltype = in_flush ? 2'd0 : h.ltype;
	assign num   = in_flush ? 24'd0 : h.num;
	assign last  = !in_flush;
	assign go_out = out_valid && out_ready;
	assign pop = go_out && !in_flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0; idx_q <= '0; wbank_q <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				qd_q[wr_q] <= cmd;
				qb_q[wr_q] <= wbank_q;
				wr_q <= ~wr_q;
				if (cmd.flush) wbank_q <= ~wbank_q;
			end
			if (go_out) idx_q <= in_flush ? idx_q + 6'd1 : 6'd0;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, cmd_valid && cmd_ready} - {1'b0, pop};
		end
	end
endmodule

// ----- rtl/ini_line_tokenizer.sv -----
// Top level of the INI line tokenizer: front parser and back emitter.
// Depends on ilt_pkg, ilt_front, ilt_back.
`timescale 1ns / 1ps
// Takes one text byte per transaction and streams tagged tokens out of
// the emitter's command queue. A byte is accepted every cycle while the
// two-entry command queue has room; a byte that releases held trailing
// spaces emits each held space and then its own token, so input stalls
// when the queue fills, either while such a flush drains or while the
// receiver holds off. Held spaces are kept in two 32-byte banks in the
// emitter.
module ini_line_tokenizer #(
	parameter int MAX_SECTION_CHARS = 200,
	parameter int MAX_LINE_CHARS    = 4095,
	parameter int PENDING_DEPTH     = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // byte_value[7:0]
	input  logic        s_tuser,  // end_of_file
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // token_char[7:0], line_type[9:8], line_number[33:10]
	output logic [2:0]  m_tuser,  // token_kind[2:0]
	output logic        m_tlast   // run_last
);
	import ilt_pkg::*;

	cmd_t       cmd;
	logic       cmd_valid, cmd_ready, wr_en;
	logic [4:0] wr_addr;
	logic [7:0] wr_data, ch;
	logic [1:0] ltype;
	logic [23:0] num;

	ilt_front #(
		.MAX_SECTION_CHARS(MAX_SECTION_CHARS),
		.MAX_LINE_CHARS(MAX_LINE_CHARS),
		.PENDING_DEPTH(PENDING_DEPTH)
	) u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.in_byte(s_tdata), .in_eof(s_tuser), .cmd_valid, .cmd_ready, .cmd,
		.wr_en, .wr_addr, .wr_data
	);

	ilt_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd, .wr_en, .wr_addr, .wr_data,
		.out_valid(m_tvalid), .out_ready(m_tready), .kind(m_tuser), .ch,
		.ltype, .num, .last(m_tlast)
	);

	assign m_tdata = {6'd0, num, ltype, ch};
endmodule

// ----- rtl/ilt_checker.sv -----
// Port-level checker for the INI line tokenizer, bound to the top level.
// Depends on ini_line_tokenizer.
`timescale 1ns / 1ps
module ilt_props (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= 3'd5) else $error("bad kind");
	a_endlast: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser >= 3'd3 |-> m_tlast) else $error("line end not last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output dropped");
endmodule

bind ini_line_tokenizer ilt_props u_ilt_props (.*);
